### sv/sync_word_frame_receiver_assert.svh
// assertion macros for the sync word frame receiver checker
// expects signals clk and arst_n in the scope of use
`ifndef SYNC_WORD_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_WORD_FRAME_RECEIVER_ASSERT_SVH

// clocked check, off while reset is asserted
`define SWFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SWFR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/swfr_pkg.sv
// shared constants for the sync word frame receiver
// no dependencies
`timescale 1ns / 1ps

package swfr_pkg;

	localparam int PAYLOAD_BYTES = 32;
	localparam int BYTE_W = 8;
	localparam int POS_W = 6;
	localparam int PHASE_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_TDATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THIRD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FOURTH = 2'd3;

	// frame phases
	localparam logic [PHASE_W-1:0] PH_HUNT1 = 4'd0;
	localparam logic [PHASE_W-1:0] PH_HUNT2 = 4'd1;
	localparam logic [PHASE_W-1:0] PH_HUNT3 = 4'd2;
	localparam logic [PHASE_W-1:0] PH_HUNT4 = 4'd3;
	localparam logic [PHASE_W-1:0] PH_RECV = 4'd4;
	localparam logic [PHASE_W-1:0] PH_TAIL1 = 4'd5;
	localparam logic [PHASE_W-1:0] PH_TAIL2 = 4'd6;
	localparam logic [PHASE_W-1:0] PH_TAIL3 = 4'd7;
	localparam logic [PHASE_W-1:0] PH_TAIL4 = 4'd8;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES - 1);

endpackage

### sv/swfr_cell.sv
// one byte cell of the payload shift chain
// depends on swfr_pkg
`timescale 1ns / 1ps

module swfr_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [swfr_pkg::BYTE_W-1:0] d,
	output logic [swfr_pkg::BYTE_W-1:0] q
);

	logic [swfr_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

### sv/swfr_chain.sv
// payload store as a row of byte cells, bytes enter at the tail and leave at the head
// depends on swfr_pkg and swfr_cell
`timescale 1ns / 1ps

module swfr_chain (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [swfr_pkg::BYTE_W-1:0] din,
	output logic [swfr_pkg::BYTE_W-1:0] head
);

	logic [swfr_pkg::BYTE_W-1:0] link [swfr_pkg::PAYLOAD_BYTES+1];

	assign link[swfr_pkg::PAYLOAD_BYTES] = din;

	for (genvar i = 0; i < swfr_pkg::PAYLOAD_BYTES; i++) begin : g_cell
		swfr_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (link[i+1]),
			.q     (link[i])
		);
	end

	assign head = link[0];

endmodule

### sv/sync_word_frame_receiver.sv
// top level of the sync word frame receiver: phase tracking, config registers, readout
// depends on swfr_pkg and swfr_chain
`timescale 1ns / 1ps

// Usage
// s_* channel: one received byte per transfer in s_tdata[7:0].
// m_* channel: payload bytes of a confirmed frame, s_tdata-independent burst of
//   PAYLOAD_BYTES transfers; m_tdata = payload_byte [7:0], byte_position [13:8],
//   zeros above; m_tlast marks the final byte of the frame.
// cfg_*: write the four sync bytes by index while the block is idle.
// Output timing: the first payload byte is offered in the cycle after the transfer of the
//   last trailing sync byte; the rest follow one per cycle while m_tready is high.
// Throughput: one input byte per cycle while no burst is pending; during a burst
//   s_tready is low until all PAYLOAD_BYTES bytes are read out. The readout rate
//   is set by the single byte chain, which shifts either on input or on output,
//   never both.
// Reset: phase returns to the hunt for the first sync byte, sync bytes clear to
//   zero, no burst is pending. Payload cells are not reset.
// Stall: if m_tready is low the current byte and position hold and the input
//   side stays blocked until the burst is fully drained.

module sync_word_frame_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [swfr_pkg::BYTE_W-1:0]       s_tdata,  // rx_byte [7:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [swfr_pkg::OUT_TDATA_W-1:0]  m_tdata,  // payload_byte [7:0], byte_position [13:8]
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [swfr_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [swfr_pkg::BYTE_W-1:0]       cfg_data
);

	logic [swfr_pkg::BYTE_W-1:0]  sync1_q, sync2_q, sync3_q, sync4_q;
	logic [swfr_pkg::PHASE_W-1:0] phase_q;
	logic [swfr_pkg::POS_W-1:0]   fill_q;
	logic [swfr_pkg::POS_W-1:0]   pos_q;
	logic                         emit_q;
	logic                         in_xfer, out_xfer, chain_shift;
	logic [swfr_pkg::BYTE_W-1:0]  rx, head;

	assign rx       = s_tdata;
	assign s_tready = !emit_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign chain_shift = (in_xfer && phase_q == swfr_pkg::PH_RECV) || out_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync1_q <= '0;
			sync2_q <= '0;
			sync3_q <= '0;
			sync4_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				swfr_pkg::REG_SYNC_FIRST:  sync1_q <= cfg_data;
				swfr_pkg::REG_SYNC_SECOND: sync2_q <= cfg_data;
				swfr_pkg::REG_SYNC_THIRD:  sync3_q <= cfg_data;
				swfr_pkg::REG_SYNC_FOURTH: sync4_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swfr_pkg::PH_HUNT1;
			fill_q  <= '0;
		end else if (in_xfer) begin
			case (phase_q)
				swfr_pkg::PH_HUNT1: begin
					phase_q <= (rx == sync1_q) ? swfr_pkg::PH_HUNT2 : swfr_pkg::PH_HUNT1;
				end
				swfr_pkg::PH_HUNT2: begin
					if (rx == sync2_q) phase_q <= swfr_pkg::PH_HUNT3;
					else if (rx == sync1_q) phase_q <= swfr_pkg::PH_HUNT2;
					else phase_q <= swfr_pkg::PH_HUNT1;
				end
				swfr_pkg::PH_HUNT3: begin
					phase_q <= (rx == sync3_q) ? swfr_pkg::PH_HUNT4 : swfr_pkg::PH_HUNT1;
				end
				swfr_pkg::PH_HUNT4: begin
					phase_q <= (rx == sync4_q) ? swfr_pkg::PH_RECV : swfr_pkg::PH_HUNT1;
				end
				swfr_pkg::PH_RECV: begin
					if (fill_q == swfr_pkg::LAST_POS) begin
						fill_q  <= '0;
						phase_q <= swfr_pkg::PH_TAIL1;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				swfr_pkg::PH_TAIL1: begin
					if (rx == sync1_q) phase_q <= swfr_pkg::PH_TAIL2;
					else begin
						phase_q <= swfr_pkg::PH_HUNT1;
						fill_q  <= '0;
					end
				end
				swfr_pkg::PH_TAIL2: begin
					if (rx == sync2_q) phase_q <= swfr_pkg::PH_TAIL3;
					else begin
						phase_q <= swfr_pkg::PH_HUNT1;
						fill_q  <= '0;
					end
				end
				swfr_pkg::PH_TAIL3: begin
					if (rx == sync3_q) phase_q <= swfr_pkg::PH_TAIL4;
					else begin
						phase_q <= swfr_pkg::PH_HUNT1;
						fill_q  <= '0;
					end
				end
				swfr_pkg::PH_TAIL4: begin
					fill_q <= '0;
					phase_q <= (rx == sync4_q) ? swfr_pkg::PH_RECV : swfr_pkg::PH_HUNT1;
				end
				default: begin
					phase_q <= swfr_pkg::PH_HUNT1;
					fill_q  <= '0;
				end
			endcase
		end
	end

	// readout burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			pos_q  <= '0;
		end else if (out_xfer) begin
			if (pos_q == swfr_pkg::LAST_POS) begin
				emit_q <= 1'b0;
				pos_q  <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end else if (in_xfer && phase_q == swfr_pkg::PH_TAIL4 && rx == sync4_q) begin
			emit_q <= 1'b1;
			pos_q  <= '0;
		end
	end

	swfr_chain u_chain (
		.clk   (clk),
		.shift (chain_shift),
		.din   (rx),
		.head  (head)
	);

	assign m_tvalid = emit_q;
	assign m_tlast  = emit_q && (pos_q == swfr_pkg::LAST_POS);
	assign m_tdata  = {2'b00, pos_q, head};

endmodule

### sv/swfr_checker.sv
// port-level checks for the sync word frame receiver, bound to the top level
// depends on swfr_pkg and sync_word_frame_receiver_assert.svh
`timescale 1ns / 1ps
`include "sync_word_frame_receiver_assert.svh"

module swfr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [swfr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                              m_tlast
);

	`SWFR_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !m_tvalid, "output valid during reset")

	`SWFR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")

	`SWFR_ASSERT(a_in_blocked, m_tvalid |-> !s_tready, "input taken during readout burst")

	`SWFR_ASSERT(a_pos_step, m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[13:8] == 6'($past(m_tdata[13:8]) + 6'd1), "byte position did not advance")

	`SWFR_ASSERT(a_last_end, m_tvalid && m_tready && m_tlast |=> !m_tvalid && m_tdata[13:8] == 6'd0, "burst did not end after last byte")

endmodule

bind sync_word_frame_receiver swfr_checker u_swfr_checker (.*);
